/* src/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

   // Transaction field widths, fixed by the bus format
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned SIZE_W     = 8;
   localparam int unsigned EID_W      = 16;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned BID_W      = 16;
   localparam int unsigned POOL_W     = 8;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [POOL_W-1:0] POOL_RESET = 8'd128;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_ERASE  = 2'd1,
      CMD_DEFRAG = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FAIL    = 2'd1,
      ST_ILLEGAL = 2'd2
   } status_type;

   // What every cell of the row does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_ROTATE = 2'd1,
      CELL_SORT   = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;   // odd-even transposition phase
   } cell_ctrl_type;

endpackage

/* src/ffba_cell.sv */
// One pool cell: owner tag register with rotate and compare-exchange moves.
module ffba_cell #(
   parameter int unsigned ID_BITS = 16,
   parameter bit          IS_ODD  = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ffba_pkg::cell_ctrl_type ctrl,
   input  logic [ID_BITS-1:0]    shift_in,
   input  logic [ID_BITS-1:0]    left_in,
   input  logic [ID_BITS-1:0]    right_in,
   output logic [ID_BITS-1:0]    owner_out
);
   import ffba_pkg::*;

   logic [ID_BITS-1:0] owner_ff;
   logic [ID_BITS-1:0] owner_in;
   logic               lower;

   // lower member of the pair pairs with the right neighbour
   assign lower = (IS_ODD == ctrl.phase);

   always_comb begin
      owner_in = owner_ff;
      case (ctrl.op)
         CELL_ROTATE: owner_in = shift_in;
         CELL_SORT: begin
            if (lower) begin
               if (owner_ff == '0 && right_in != '0) owner_in = right_in;
            end else begin
               if (left_in == '0 && owner_ff != '0) owner_in = left_in;
            end
         end
         default: owner_in = owner_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= '0;
      end else begin
         owner_ff <= owner_in;
      end
   end

   assign owner_out = owner_ff;

endmodule

/* src/first_fit_block_allocator_top.sv */
// Top level: command sequencer, response register and the row of pool cells.
// A successful allocate runs a scan pass and a fill pass before it responds; a failed
// allocate and an illegal erase respond after one pass; legal erase, defragment and
// the unused code 3 give no response. Commands are taken only in idle, one at a time;
// one row rotation per pass; a held response stalls the finish state.
// Reset: synchronous; clears all owner tags, the id counter and sets pool_size to 128.
module first_fit_block_allocator_top #(
   parameter int unsigned MEM_CELLS = 128,
   parameter int unsigned ID_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tuser [1:0] command; tdata [7:0] request_size, [23:8] erase_id
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ffba_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [ffba_pkg::CMD_W-1:0]        req_tuser,
   // response: tuser [1:0] status; tdata [15:0] block_id
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ffba_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [ffba_pkg::STATUS_W-1:0]     rsp_tuser,
   // pool_size register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ffba_pkg::POOL_W-1:0]       csr_wdata
);
   import ffba_pkg::*;

   localparam int unsigned IDX_W = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
   localparam int unsigned RUN_W = $clog2(MEM_CELLS + 1);
   localparam int unsigned SW    = (RUN_W > SIZE_W) ? RUN_W : SIZE_W;
   localparam int unsigned PW    = (IDX_W > POOL_W) ? IDX_W : POOL_W;
   localparam int unsigned CW    = (ID_BITS > BID_W) ? ID_BITS : BID_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_FILL   = 6'b000100,
      S_ERASE  = 6'b001000,
      S_DEFRAG = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type            state_ff,  state_in;
   cmd_type              cmd_ff,    cmd_in;
   logic [SIZE_W-1:0]    size_ff,   size_in;
   logic [EID_W-1:0]     eid_ff,    eid_in;
   logic [IDX_W-1:0]     idx_ff,    idx_in;
   logic [RUN_W-1:0]     run_ff,    run_in;
   logic [IDX_W-1:0]     start_ff,  start_in;
   logic [IDX_W-1:0]     end_ff,    end_in;
   logic                 found_ff,  found_in;
   logic                 hit_ff,    hit_in;
   logic [ID_BITS-1:0]   last_id_ff, last_id_in;
   logic [POOL_W-1:0]    pool_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [BID_W-1:0]     rsp_id_ff, rsp_id_in;

   // cell row; cell 0 is the head seen by the sequencer
   logic [ID_BITS-1:0]   owner [MEM_CELLS];
   logic [ID_BITS-1:0]   head;
   logic [ID_BITS-1:0]   ring_val;
   cell_ctrl_type        cell_ctrl;

   logic                 idx_last;
   logic                 in_pool;
   logic                 alloc_ok;
   logic [SW-1:0]        run_inc;
   logic                 run_done;
   logic                 in_block;
   logic                 erase_match;
   logic [CW-1:0]        last_ext;
   logic                 emit;

   assign head      = owner[0];
   assign idx_last  = (idx_ff == IDX_W'(MEM_CELLS - 1));
   // pool limit: cells below min(pool_size, MEM_CELLS)
   assign in_pool   = (PW'(idx_ff) < PW'(pool_ff));
   // zero request or exhausted id counter never allocates
   assign alloc_ok  = (size_ff != '0) && (last_id_ff != '1);
   assign run_inc   = SW'(run_ff) + SW'(1);
   assign run_done  = (run_inc >= SW'(size_ff));
   assign in_block  = (idx_ff >= start_ff) && (idx_ff <= end_ff);
   assign erase_match = (eid_ff != '0) && (CW'(eid_ff) == CW'(head));
   assign last_ext  = CW'(last_id_ff);
   assign emit      = (cmd_ff == CMD_ALLOC) || ((cmd_ff == CMD_ERASE) && !hit_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      eid_in        = eid_ff;
      idx_in        = idx_last ? '0 : idx_ff + IDX_W'(1);
      run_in        = run_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      last_id_in    = last_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      ring_val      = head;
      cell_ctrl.op    = CELL_HOLD;
      cell_ctrl.phase = idx_ff[0];

      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               size_in  = req_tdata[0 +: SIZE_W];
               eid_in   = req_tdata[SIZE_W +: EID_W];
               run_in   = '0;
               found_in = 1'b0;
               hit_in   = 1'b0;
               unique case (cmd_type'(req_tuser))
                  CMD_ALLOC:  state_in = S_SCAN;
                  CMD_ERASE:  state_in = S_ERASE;
                  CMD_DEFRAG: state_in = S_DEFRAG;
                  default:    state_in = S_FINISH;
               endcase
            end
         end
         S_SCAN: begin
            // first pass: look for the lowest free run, row rotates unchanged
            cell_ctrl.op = CELL_ROTATE;
            if (alloc_ok && !found_ff && in_pool) begin
               if (head == '0) begin
                  if (run_ff == '0) start_in = idx_ff;
                  if (run_done) begin
                     found_in = 1'b1;
                     end_in   = idx_ff;
                  end else begin
                     run_in = run_inc[RUN_W-1:0];
                  end
               end else begin
                  run_in = '0;
               end
            end
            if (idx_last) begin
               if (found_in) begin
                  last_id_in = last_id_ff + ID_BITS'(1);
                  state_in   = S_FILL;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FILL: begin
            // second pass: tag the chosen run with the new id
            cell_ctrl.op = CELL_ROTATE;
            if (in_block) ring_val = last_id_ff;
            if (idx_last) state_in = S_FINISH;
         end
         S_ERASE: begin
            cell_ctrl.op = CELL_ROTATE;
            if (erase_match) begin
               ring_val = '0;
               hit_in   = 1'b1;
            end
            if (idx_last) state_in = S_FINISH;
         end
         S_DEFRAG: begin
            // MEM_CELLS rounds of odd-even transposition push free cells to the end
            cell_ctrl.op = CELL_SORT;
            if (idx_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!emit) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff == CMD_ALLOC && found_ff) begin
                  rsp_status_in = ST_OK;
                  rsp_id_in     = last_ext[BID_W-1:0];
               end else if (cmd_ff == CMD_ALLOC) begin
                  rsp_status_in = ST_FAIL;
                  rsp_id_in     = '0;
               end else begin
                  rsp_status_in = ST_ILLEGAL;
                  rsp_id_in     = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         last_id_ff   <= '0;
         pool_ff      <= POOL_RESET;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= CMD_NONE;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         hit_ff       <= hit_in;
         last_id_ff   <= last_id_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
         if (csr_valid) pool_ff <= csr_wdata;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      eid_ff        <= eid_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   // row of cells: rotate towards the head, last cell takes the head value back or its replacement
   for (genvar k = 0; k < MEM_CELLS; k++) begin : g_cell
      localparam int unsigned PRV = (k == 0) ? k : k - 1;
      localparam int unsigned NXT = (k == MEM_CELLS - 1) ? k : k + 1;
      ffba_cell #(
         .ID_BITS (ID_BITS),
         .IS_ODD  (k % 2 == 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .shift_in  ((k == MEM_CELLS - 1) ? ring_val : owner[NXT]),
         .left_in   (owner[PRV]),
         .right_in  (owner[NXT]),
         .owner_out (owner[k])
      );
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_id_ff);
   assign rsp_tuser  = rsp_status_ff;
   assign csr_ready  = 1'b1;

   // accepted transaction always leaves idle in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != S_IDLE)
      else $error("idle right after an accepted transaction");

   // a found run is never empty or reversed
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (start_ff <= end_ff) && found_ff)
      else $error("fill pass without a valid run");

   // the tag written during fill is never the free marker
   a_fill_id: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (last_id_ff != '0))
      else $error("fill pass with a zero id");

endmodule
